// ----- hdl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Operation and status codes shared by the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  typedef logic [2:0] func_t;
  typedef logic [2:0] status_t;

  localparam func_t FN_INS_FRONT = 3'd0;
  localparam func_t FN_INS_BACK  = 3'd1;
  localparam func_t FN_INS_AT    = 3'd2;
  localparam func_t FN_DEL_FRONT = 3'd3;
  localparam func_t FN_DEL_BACK  = 3'd4;
  localparam func_t FN_DEL_AT    = 3'd5;
  localparam func_t FN_SEARCH    = 3'd6;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_BOUNDS    = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_INVALID   = 3'd5;

endpackage

`default_nettype wire

// ----- hdl/positional_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Dense ordered list of signed 32-bit values, with a count, in a two-port
// memory. Inserts, deletes and searches walk the memory one entry at a time.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  command   func, value, position                  start, taken when !busy
//  result    status, found_index, length            done, one cycle
//
//  Insert reads and rewrites each entry it moves (S_INS_RD, S_INS_WR), then
//  writes the new value (S_INS_FIN); delete reads and rewrites each entry it
//  moves (S_DEL_RD, S_DEL_WR); search reads and compares each entry in turn
//  (S_SRCH_RD, S_SRCH_CMP). A search of a full list takes longest. busy is
//  high from the cycle after start and low again in the cycle done is high.
//  Synchronous reset empties the list; memory contents are not cleared.
//  The result cannot be stalled; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ple_pkg::func_t        func,
  input  wire logic signed [31:0]    value,
  input  wire logic signed [7:0]     position,
  output logic                       done,
  output ple_pkg::status_t           status,
  output logic [3:0]                 found_index,
  output logic [4:0]                 length
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW + 1 : 8;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_INS_FIN  = 4'd4;
  localparam logic [3:0] S_DEL_RD   = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_SRCH_RD  = 4'd7;
  localparam logic [3:0] S_SRCH_CMP = 4'd8;

  logic [3:0]          state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       tgt, tgt_next;
  ple_pkg::func_t      op;
  logic signed [31:0]  key;
  logic [7:0]          pos;

  logic [31:0]         mem [CAPACITY];
  logic [31:0]         rdata;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [31:0]         wdata;

  logic                emit;
  ple_pkg::status_t    emit_status;
  logic [CW-1:0]       emit_found;

  logic [CMPW-1:0]     cnt_x, tpos_x;
  logic                is_ins, is_del;

  assign busy = (state != S_IDLE);

  always_comb begin
    cnt_x  = CMPW'(count);
    is_ins = (op == ple_pkg::FN_INS_FRONT) || (op == ple_pkg::FN_INS_BACK) ||
             (op == ple_pkg::FN_INS_AT);
    is_del = (op == ple_pkg::FN_DEL_FRONT) || (op == ple_pkg::FN_DEL_BACK) ||
             (op == ple_pkg::FN_DEL_AT);
    case (op)
      ple_pkg::FN_INS_BACK: tpos_x = cnt_x;
      ple_pkg::FN_DEL_BACK: tpos_x = cnt_x - CMPW'(1);
      ple_pkg::FN_INS_AT,
      ple_pkg::FN_DEL_AT:   tpos_x = CMPW'(pos[6:0]);
      default:              tpos_x = '0;
    endcase
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    tgt_next    = tgt;
    emit        = 1'b0;
    emit_status = ple_pkg::ST_INVALID;
    emit_found  = '0;
    we          = 1'b0;
    waddr       = idx[AW-1:0];
    wdata       = rdata;
    raddr       = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        tgt_next = CW'(tpos_x);
        if (is_ins) begin
          if (op == ple_pkg::FN_INS_AT && pos[7]) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_INVALID;
          end else if (tpos_x > cnt_x) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_BOUNDS;
          end else if (cnt_x >= CMPW'(CAPACITY)) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_FULL;
          end else begin
            idx_next = count;
            state_next = (cnt_x > tpos_x) ? S_INS_RD : S_INS_FIN;
          end
        end else if (is_del) begin
          if (op == ple_pkg::FN_DEL_AT && pos[7]) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_INVALID;
          end else if (count == '0) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_EMPTY;
          end else if (tpos_x >= cnt_x) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_BOUNDS;
          end else if ((tpos_x + CMPW'(1)) < cnt_x) begin
            idx_next = CW'(tpos_x);
            state_next = S_DEL_RD;
          end else begin
            count_next = count - CW'(1);
            emit = 1'b1;
            emit_status = ple_pkg::ST_OK;
          end
        end else if (op == ple_pkg::FN_SEARCH) begin
          if (count == '0) begin
            emit = 1'b1;
            emit_status = ple_pkg::ST_NOT_FOUND;
          end else begin
            idx_next = '0;
            state_next = S_SRCH_RD;
          end
        end else begin
          emit = 1'b1;
          emit_status = ple_pkg::ST_INVALID;
        end
      end
      S_INS_RD: begin
        raddr = AW'(idx - CW'(1));
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
        idx_next = idx - CW'(1);
        state_next = ((idx - CW'(1)) > tgt) ? S_INS_RD : S_INS_FIN;
      end
      S_INS_FIN: begin
        we = 1'b1;
        waddr = tgt[AW-1:0];
        wdata = key;
        count_next = count + CW'(1);
        emit = 1'b1;
        emit_status = ple_pkg::ST_OK;
      end
      S_DEL_RD: begin
        raddr = AW'(idx + CW'(1));
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
        idx_next = idx + CW'(1);
        if ((idx + CW'(2)) < count) begin
          state_next = S_DEL_RD;
        end else begin
          count_next = count - CW'(1);
          emit = 1'b1;
          emit_status = ple_pkg::ST_OK;
        end
      end
      S_SRCH_RD: begin
        raddr = idx[AW-1:0];
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata == key) begin
          emit = 1'b1;
          emit_status = ple_pkg::ST_OK;
          emit_found = idx;
        end else if ((idx + CW'(1)) >= count) begin
          emit = 1'b1;
          emit_status = ple_pkg::ST_NOT_FOUND;
        end else begin
          idx_next = idx + CW'(1);
          state_next = S_SRCH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    if (start && !busy) begin
      op  <= func;
      key <= value;
      pos <= position;
    end
    if (emit) begin
      status      <= emit_status;
      found_index <= 4'(32'(emit_found));
      length      <= 5'(32'(count_next));
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an operation in progress");

  a_start_decide: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_DECIDE)
    else $error("accepted transaction did not enter decode");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (done && status == ple_pkg::ST_OK && is_ins) |-> count == $past(count) + CW'(1))
    else $error("successful insert did not grow the list");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("memory write while idle");
`endif

endmodule

`default_nettype wire
